// ----- design/hbs_pkg.sv -----
// Shared types, constants and helpers of the height grid bilinear sampler.
`timescale 1ns / 1ps
package hbs_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_DEPTH  = 256;
  localparam int GRID_CELLS = MAX_WIDTH * MAX_DEPTH;
  localparam int ADDR_W     = $clog2(GRID_CELLS);
  localparam int BANK_DEPTH = GRID_CELLS / 2;
  localparam int BANK_AW    = ADDR_W - 1;

  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam int ODEPTH = 8;
  localparam int OPTR_W = $clog2(ODEPTH);
  localparam int OCNT_W = OPTR_W + 1;

  localparam logic [1:0] REG_GRID_WIDTH     = 2'd0;
  localparam logic [1:0] REG_GRID_DEPTH     = 2'd1;
  localparam logic [1:0] REG_INV_CELL_SCALE = 2'd2;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic [8:0]  grid_width;
    logic [8:0]  grid_depth;
    logic [15:0] inv_cell_scale;
  } hbs_cfg_t;

  typedef struct packed {
    logic              sample;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       hval;
    logic [16:0]       w00;
    logic [16:0]       w10;
    logic [16:0]       w01;
    logic [16:0]       w11;
    logic              clamp;
  } hbs_task_t;

  typedef struct packed {
    logic [7:0] idx;
    logic [8:0] w;
    logic       clamp;
  } hbs_loc_t;

  function automatic logic [8:0] sat_size(input logic [8:0] v, input logic [8:0] maxv);
    logic [8:0] r;
    if (v < 9'd2) r = 9'd2;
    else if (v > maxv) r = maxv;
    else r = v;
    return r;
  endfunction

  // c: signed cell coordinate, f: fraction, size: cells in use
  function automatic hbs_loc_t locate(input logic signed [23:0] c, input logic [7:0] f,
                                      input logic [8:0] size);
    hbs_loc_t   r;
    logic [8:0] last;
    logic [8:0] two_less;
    last = size - 9'd1;
    two_less = size - 9'd2;
    if (c < 0) begin
      r.idx = 8'd0; r.w = 9'd0; r.clamp = 1'b1;
    end else if (c > $signed({15'd0, last}) || (c == $signed({15'd0, last}) && f != 8'd0)) begin
      r.idx = two_less[7:0]; r.w = 9'd256; r.clamp = 1'b1;
    end else if (c == $signed({15'd0, last})) begin
      r.idx = two_less[7:0]; r.w = 9'd256; r.clamp = 1'b0;
    end else begin
      r.idx = c[7:0]; r.w = {1'b0, f}; r.clamp = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- design/hbs_if.sv -----
// Channel interfaces: item input, result output, configuration write.
`timescale 1ns / 1ps
interface hbs_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [7:0]         cell_x;
  logic [7:0]         cell_z;
  logic signed [15:0] height_value;
  logic signed [23:0] sample_x;
  logic signed [23:0] sample_z;
  modport source (output valid, op, cell_x, cell_z, height_value, sample_x, sample_z,
                  input ready);
  modport sink (input valid, op, cell_x, cell_z, height_value, sample_x, sample_z,
                output ready);
endinterface

interface hbs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] height_out;
  logic               clamped;
  modport source (output valid, height_out, clamped, input ready);
  modport sink (input valid, height_out, clamped, output ready);
endinterface

interface hbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/hbs_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module hbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;
endmodule

// ----- design/hbs_front.sv -----
// Front end: accepts words, scales and locates samples, forms addresses and weights.
`timescale 1ns / 1ps
module hbs_front (
  input  logic                    clk,
  input  logic                    rst_n,
  hbs_in_if.sink                  in_ch,
  input  hbs_pkg::hbs_cfg_t       cfg,
  input  logic [hbs_pkg::QCNT_W-1:0] q_cnt,
  output logic                    push,
  output hbs_pkg::hbs_task_t      push_task
);
  localparam int QCNT_W_L = hbs_pkg::QCNT_W + 1;

  logic               f1_v_r, f1_v_nxt;
  logic               f1_op_r;
  logic [7:0]         f1_x_r, f1_z_r;
  logic [15:0]        f1_h_r;
  logic signed [39:0] f1_px_r, f1_pz_r;
  logic signed [40:0] px_full, pz_full;

  logic               f2_v_r, f2_v_nxt;
  logic               f2_sample_r, f2_we_r, f2_clamp_r;
  logic [7:0]         f2_cx_r, f2_cz_r;
  logic [8:0]         f2_wx_r, f2_wz_r;
  logic [15:0]        f2_h_r;

  hbs_pkg::hbs_loc_t  loc_x, loc_z;
  logic               accept;
  logic [QCNT_W_L-1:0] occ;
  logic [16:0]        addr_full;
  logic [8:0]         iwx, iwz;

  assign occ = {1'b0, q_cnt} + QCNT_W_L'(f1_v_r) + QCNT_W_L'(f2_v_r);
  assign in_ch.ready = (occ < QCNT_W_L'(hbs_pkg::QDEPTH));
  assign accept = in_ch.valid && in_ch.ready;

  assign px_full = in_ch.sample_x * $signed({1'b0, cfg.inv_cell_scale});
  assign pz_full = in_ch.sample_z * $signed({1'b0, cfg.inv_cell_scale});

  assign f1_v_nxt = accept;
  assign f2_v_nxt = f1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else begin
      f1_v_r <= f1_v_nxt;
      f2_v_r <= f2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_op_r <= in_ch.op;
      f1_x_r  <= in_ch.cell_x;
      f1_z_r  <= in_ch.cell_z;
      f1_h_r  <= in_ch.height_value;
      f1_px_r <= px_full[39:0];
      f1_pz_r <= pz_full[39:0];
    end
  end

  assign loc_x = hbs_pkg::locate(f1_px_r[39:16], f1_px_r[15:8], cfg.grid_width);
  assign loc_z = hbs_pkg::locate(f1_pz_r[39:16], f1_pz_r[15:8], cfg.grid_depth);

  always_ff @(posedge clk) begin
    if (f1_v_r) begin
      f2_sample_r <= (f1_op_r == hbs_pkg::OP_SAMPLE);
      f2_h_r      <= f1_h_r;
      if (f1_op_r == hbs_pkg::OP_SAMPLE) begin
        f2_we_r    <= 1'b0;
        f2_cx_r    <= loc_x.idx;
        f2_cz_r    <= loc_z.idx;
        f2_wx_r    <= loc_x.w;
        f2_wz_r    <= loc_z.w;
        f2_clamp_r <= loc_x.clamp || loc_z.clamp;
      end else begin
        f2_we_r    <= ({1'b0, f1_x_r} < cfg.grid_width) && ({1'b0, f1_z_r} < cfg.grid_depth);
        f2_cx_r    <= f1_x_r;
        f2_cz_r    <= f1_z_r;
        f2_wx_r    <= 9'd0;
        f2_wz_r    <= 9'd0;
        f2_clamp_r <= 1'b0;
      end
    end
  end

  assign addr_full = ({9'd0, f2_cx_r} * {8'd0, cfg.grid_depth}) + {9'd0, f2_cz_r};
  assign iwx = 9'd256 - f2_wx_r;
  assign iwz = 9'd256 - f2_wz_r;

  assign push = f2_v_r;
  always_comb begin
    push_task.sample = f2_sample_r;
    push_task.we     = f2_we_r;
    push_task.addr   = addr_full[hbs_pkg::ADDR_W-1:0];
    push_task.hval   = f2_h_r;
    push_task.w00    = {8'd0, iwx} * {8'd0, iwz};
    push_task.w10    = {8'd0, f2_wx_r} * {8'd0, iwz};
    push_task.w01    = {8'd0, iwx} * {8'd0, f2_wz_r};
    push_task.w11    = {8'd0, f2_wx_r} * {8'd0, f2_wz_r};
    push_task.clamp  = f2_clamp_r;
  end
endmodule

// ----- design/hbs_queue.sv -----
// Task queue between front end and back end.
`timescale 1ns / 1ps
module hbs_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  hbs_pkg::hbs_task_t         push_task,
  input  logic                       pop,
  output hbs_pkg::hbs_task_t         head,
  output logic [hbs_pkg::QCNT_W-1:0] cnt
);
  hbs_pkg::hbs_task_t               mem_r [hbs_pkg::QDEPTH];
  logic [hbs_pkg::QPTR_W-1:0]       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [hbs_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;

  assign wp_nxt  = push ? wp_r + 1'b1 : wp_r;
  assign rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
  assign cnt_nxt = cnt_r + hbs_pkg::QCNT_W'(push) - hbs_pkg::QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_task;
  end

  assign head = mem_r[rp_r];
  assign cnt  = cnt_r;
endmodule

// ----- design/hbs_back.sv -----
// Back end: banked grid memory, bilinear blend, rounding and result buffer.
`timescale 1ns / 1ps
module hbs_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hbs_pkg::hbs_cfg_t          cfg,
  input  hbs_pkg::hbs_task_t         head,
  input  logic [hbs_pkg::QCNT_W-1:0] q_cnt,
  output logic                       pop,
  hbs_out_if.source                  out_ch
);
  localparam int AW  = hbs_pkg::ADDR_W;
  localparam int BAW = hbs_pkg::BANK_AW;
  localparam int OCW = hbs_pkg::OCNT_W + 1;

  logic [AW:0]    a_ext, b_ext, a_inc, b_inc;
  logic [AW-1:0]  b_base;
  logic           we_even, we_odd;
  logic [15:0]    ae_q, ao_q, be_q, bo_q;

  logic           s1_v_r, s2_v_r, s3_v_r;
  logic           s1_ao_r, s1_bo_r, s1_cl_r, s2_cl_r, s3_cl_r;
  logic [16:0]    s1_w00_r, s1_w10_r, s1_w01_r, s1_w11_r;
  logic signed [33:0] s2_p00_r, s2_p10_r, s2_p01_r, s2_p11_r;
  logic signed [35:0] s3_sum_r, rnd;
  logic signed [15:0] h00, h01, h10, h11;

  logic [15:0]    ob_h_r [hbs_pkg::ODEPTH];
  logic           ob_c_r [hbs_pkg::ODEPTH];
  logic [hbs_pkg::OPTR_W-1:0] ob_wp_r, ob_rp_r;
  logic [hbs_pkg::OCNT_W-1:0] ob_cnt_r, ob_cnt_nxt;
  logic           ob_pop;
  logic [OCW-1:0] occ;

  assign occ = {1'b0, ob_cnt_r} + OCW'(s1_v_r) + OCW'(s2_v_r) + OCW'(s3_v_r);
  assign pop = (q_cnt != '0) && (occ < OCW'(hbs_pkg::ODEPTH));

  // copy A serves z and z+1 of column x, copy B of column x+1; writes go to both
  assign a_ext  = {1'b0, head.addr};
  assign b_ext  = a_ext + {8'd0, cfg.grid_depth};
  assign b_base = head.sample ? b_ext[AW-1:0] : head.addr;
  assign a_inc  = a_ext + 1'b1;
  assign b_inc  = {1'b0, b_base} + 1'b1;
  assign we_even = pop && head.we && !head.addr[0];
  assign we_odd  = pop && head.we && head.addr[0];

  hbs_ram #(.WIDTH(16), .DEPTH(hbs_pkg::BANK_DEPTH)) u_ram_ae (
    .clk(clk), .we(we_even), .addr(a_inc[BAW:1]), .wdata(head.hval), .rdata(ae_q));
  hbs_ram #(.WIDTH(16), .DEPTH(hbs_pkg::BANK_DEPTH)) u_ram_ao (
    .clk(clk), .we(we_odd), .addr(head.addr[BAW:1]), .wdata(head.hval), .rdata(ao_q));
  hbs_ram #(.WIDTH(16), .DEPTH(hbs_pkg::BANK_DEPTH)) u_ram_be (
    .clk(clk), .we(we_even), .addr(b_inc[BAW:1]), .wdata(head.hval), .rdata(be_q));
  hbs_ram #(.WIDTH(16), .DEPTH(hbs_pkg::BANK_DEPTH)) u_ram_bo (
    .clk(clk), .we(we_odd), .addr(b_base[BAW:1]), .wdata(head.hval), .rdata(bo_q));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= pop && head.sample;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_ao_r  <= head.addr[0];
    s1_bo_r  <= b_base[0];
    s1_cl_r  <= head.clamp;
    s1_w00_r <= head.w00;
    s1_w10_r <= head.w10;
    s1_w01_r <= head.w01;
    s1_w11_r <= head.w11;
  end

  assign h00 = s1_ao_r ? ao_q : ae_q;
  assign h01 = s1_ao_r ? ae_q : ao_q;
  assign h10 = s1_bo_r ? bo_q : be_q;
  assign h11 = s1_bo_r ? be_q : bo_q;

  always_ff @(posedge clk) begin
    s2_p00_r <= h00 * $signed({1'b0, s1_w00_r});
    s2_p10_r <= h10 * $signed({1'b0, s1_w10_r});
    s2_p01_r <= h01 * $signed({1'b0, s1_w01_r});
    s2_p11_r <= h11 * $signed({1'b0, s1_w11_r});
    s2_cl_r  <= s1_cl_r;
    s3_sum_r <= 36'(s2_p00_r) + 36'(s2_p10_r) + 36'(s2_p01_r) + 36'(s2_p11_r);
    s3_cl_r  <= s2_cl_r;
  end

  assign rnd = s3_sum_r + 36'sd32768;

  assign ob_pop     = out_ch.valid && out_ch.ready;
  assign ob_cnt_nxt = ob_cnt_r + hbs_pkg::OCNT_W'(s3_v_r) - hbs_pkg::OCNT_W'(ob_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wp_r  <= '0;
      ob_rp_r  <= '0;
      ob_cnt_r <= '0;
    end else begin
      if (s3_v_r) ob_wp_r <= ob_wp_r + 1'b1;
      if (ob_pop) ob_rp_r <= ob_rp_r + 1'b1;
      ob_cnt_r <= ob_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v_r) begin
      ob_h_r[ob_wp_r] <= rnd[31:16];
      ob_c_r[ob_wp_r] <= s3_cl_r;
    end
  end

  assign out_ch.valid      = (ob_cnt_r != '0);
  assign out_ch.height_out = ob_h_r[ob_rp_r];
  assign out_ch.clamped    = ob_c_r[ob_rp_r];
endmodule

// ----- design/heightfield_bilinear_sampler_unit.sv -----
// Top level of the height grid bilinear sampler.
`timescale 1ns / 1ps
// Usage:
//   in_ch  : valid/ready words. op 0 writes height_value at (cell_x, cell_z),
//            op 1 samples at world (sample_x, sample_z), Q16.8.
//   out_ch : one word per sample, in order: height_out (Q8.8) and clamped.
//            Writes give no output word.
//   cfg_ch : index 0 grid_width, 1 grid_depth, 2 inv_cell_scale; always ready.
//            Width and depth saturate into 2..256. Write only while idle.
// Throughput: one word per cycle while in_ch.ready is high. The grid sits in
// two copies of an even/odd banked memory, so the four corner heights are
// read together. An accepted sample passes two front stages, the task queue,
// RAM read, multiply, sum and the result buffer before its result is valid.
// Reset (rst_n low, synchronous) empties the pipeline and the queues and loads
// the register defaults 256/256/256. Grid contents are undefined until written.
// When out_ch stalls, results collect in an 8-word buffer, then the task queue
// fills and in_ch.ready drops; no word is lost.
module heightfield_bilinear_sampler_unit (
  input  logic      clk,
  input  logic      rst_n,
  hbs_in_if.sink    in_ch,
  hbs_out_if.source out_ch,
  hbs_cfg_if.sink   cfg_ch
);
  hbs_pkg::hbs_cfg_t                cfg_r;
  hbs_pkg::hbs_task_t               push_task, head;
  logic                             push, pop;
  logic [hbs_pkg::QCNT_W-1:0]       q_cnt;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_width     <= 9'd256;
      cfg_r.grid_depth     <= 9'd256;
      cfg_r.inv_cell_scale <= 16'd256;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        hbs_pkg::REG_GRID_WIDTH:
          cfg_r.grid_width <= hbs_pkg::sat_size(cfg_ch.data[8:0], 9'(hbs_pkg::MAX_WIDTH));
        hbs_pkg::REG_GRID_DEPTH:
          cfg_r.grid_depth <= hbs_pkg::sat_size(cfg_ch.data[8:0], 9'(hbs_pkg::MAX_DEPTH));
        hbs_pkg::REG_INV_CELL_SCALE:
          cfg_r.inv_cell_scale <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  hbs_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .cfg(cfg_r), .q_cnt(q_cnt),
    .push(push), .push_task(push_task));

  hbs_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_task(push_task), .pop(pop),
    .head(head), .cnt(q_cnt));

  hbs_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .head(head), .q_cnt(q_cnt), .pop(pop),
    .out_ch(out_ch));

  a_out_idle_after_reset: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");

  a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_r.grid_width >= 9'd2 && cfg_r.grid_width <= 9'(hbs_pkg::MAX_WIDTH))
    else $error("grid width out of range");

  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_r.grid_depth >= 9'd2 && cfg_r.grid_depth <= 9'(hbs_pkg::MAX_DEPTH))
    else $error("grid depth out of range");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> q_cnt < hbs_pkg::QCNT_W'(hbs_pkg::QDEPTH))
    else $error("task queue overflow");
endmodule
